// ----- hw/rtl/double_ended_queue_unit_assert.svh -----
// assertion macros for the double-ended queue unit
// used by double_ended_queue_unit.sv; needs no other file
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define DQU_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("dqu check failed");

// next-cycle implication, off while reset is high
`define DQU_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("dqu check failed");

`endif

// ----- hw/rtl/dqu_pkg.sv -----
// shared types and constants for the double-ended queue unit
// no dependencies
`timescale 1ns / 1ps

package dqu_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // operation broadcast to every cell in the same cycle
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK
   } cell_op_type;

   typedef struct packed {
      cell_op_type           op;
      logic [DATA_WIDTH-1:0] word;
   } cell_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] data;
   } cell_link_type;

endpackage

// ----- hw/rtl/dqu_cell.sv -----
// one queue position: holds a word and its valid bit, shifts with neighbors
// depends on dqu_pkg
`timescale 1ns / 1ps

module dqu_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  dqu_pkg::cell_ctrl_type             ctrl,
   input  dqu_pkg::cell_link_type             left_link,
   input  dqu_pkg::cell_link_type             right_link,
   output dqu_pkg::cell_link_type             own_link,
   output logic [dqu_pkg::DATA_WIDTH-1:0]     back_word
);

   logic                           valid_ff;
   logic                           valid_in;
   logic [dqu_pkg::DATA_WIDTH-1:0] data_ff;
   logic [dqu_pkg::DATA_WIDTH-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      case (ctrl.op)
         dqu_pkg::OP_PUSH_FRONT: begin
            valid_in = left_link.valid;
            data_in  = left_link.data;
         end
         dqu_pkg::OP_POP_FRONT: begin
            valid_in = right_link.valid;
            data_in  = right_link.data;
         end
         dqu_pkg::OP_PUSH_BACK: begin
            // first free position takes the word
            if (!valid_ff && left_link.valid) begin
               valid_in = 1'b1;
               data_in  = ctrl.word;
            end
         end
         dqu_pkg::OP_POP_BACK: begin
            if (valid_ff && !right_link.valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
            valid_in = valid_ff;
            data_in  = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign own_link.valid = valid_ff;
   assign own_link.data  = data_ff;
   // only the last occupied cell contributes to the back word
   assign back_word = (valid_ff && !right_link.valid) ? data_ff : '0;

endmodule

// ----- hw/rtl/double_ended_queue_unit.sv -----
// top level of the double-ended queue unit: a row of dqu_cell positions
// depends on dqu_pkg, dqu_cell and double_ended_queue_unit_assert.svh
`timescale 1ns / 1ps

// usage
// - a command beat is taken at a rising edge with start high and busy low;
//   req_command picks push front, push back, pop front or pop back, and
//   req_data_value is the word to push (ignored for pops)
// - busy stays low: one beat can be taken in every cycle
// - each beat gives one result beat, shown for exactly one cycle with
//   rsp_valid high, in the cycle right after the command beat
// - the result carries the status, empty and full flags, the entry count
//   and the front and back words after the command; both words read 0
//   when the queue is empty
// - push on a full queue and pop on an empty one leave the queue as it is
//   and report overflow or underflow
// - storage is a row of DEPTH cells, front entry in cell 0; every cell
//   updates from its neighbors in the same cycle, so the rate is one
//   command per cycle at any fill level
// - synchronous reset empties the queue at once; no result beat is pending
//   after reset
// - the receiver cannot stall: each result beat must be taken as it comes

module double_ended_queue_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_command,
   input  logic [dqu_pkg::DATA_WIDTH-1:0]     req_data_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [dqu_pkg::COUNT_WIDTH-1:0]    rsp_entry_total,
   output logic [dqu_pkg::DATA_WIDTH-1:0]     rsp_front_word,
   output logic [dqu_pkg::DATA_WIDTH-1:0]     rsp_back_word
);

`include "double_ended_queue_unit_assert.svh"

   localparam int DW = dqu_pkg::DATA_WIDTH;
   localparam int CW = dqu_pkg::COUNT_WIDTH;
   localparam int ND = dqu_pkg::DEPTH;

   // command decode
   logic                   accept;
   dqu_pkg::command_type   command;
   logic                   is_push;
   logic                   queue_empty;
   logic                   queue_full;
   dqu_pkg::cell_ctrl_type ctrl;
   dqu_pkg::status_type    status_now;

   // result and count registers
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   dqu_pkg::status_type    status_ff;
   dqu_pkg::status_type    status_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;

   // cell row
   dqu_pkg::cell_link_type links [ND];
   logic [DW-1:0]          back_words [ND];
   logic [ND-1:0]          valid_vec;
   logic [DW-1:0]          back_or;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign command = dqu_pkg::command_type'(req_command);
   assign is_push = (command == dqu_pkg::CMD_PUSH_FRONT)
                 || (command == dqu_pkg::CMD_PUSH_BACK);

   // empty and full come straight from the end cells
   assign queue_empty = !links[0].valid;
   assign queue_full  = links[ND-1].valid;

   // status and the operation handed to every cell
   always_comb begin
      status_now = dqu_pkg::ST_DONE;
      ctrl.word  = req_data_value;
      ctrl.op    = dqu_pkg::OP_HOLD;
      if (accept) begin
         if (is_push && queue_full) begin
            status_now = dqu_pkg::ST_OVERFLOW;
         end else if (!is_push && queue_empty) begin
            status_now = dqu_pkg::ST_UNDERFLOW;
         end else begin
            case (command)
               dqu_pkg::CMD_PUSH_FRONT: ctrl.op = dqu_pkg::OP_PUSH_FRONT;
               dqu_pkg::CMD_PUSH_BACK:  ctrl.op = dqu_pkg::OP_PUSH_BACK;
               dqu_pkg::CMD_POP_FRONT:  ctrl.op = dqu_pkg::OP_POP_FRONT;
               dqu_pkg::CMD_POP_BACK:   ctrl.op = dqu_pkg::OP_POP_BACK;
               default:                 ctrl.op = dqu_pkg::OP_HOLD;
            endcase
         end
      end
   end

   // entry count follows the accepted operation
   always_comb begin
      count_in = count_ff;
      case (ctrl.op)
         dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PUSH_BACK: count_in = count_ff + 1'b1;
         dqu_pkg::OP_POP_FRONT, dqu_pkg::OP_POP_BACK:   count_in = count_ff - 1'b1;
         default:                                       count_in = count_ff;
      endcase
   end

   assign rsp_valid_in = accept;
   assign status_in    = accept ? status_now : status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         status_ff    <= dqu_pkg::ST_DONE;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
      end
   end

   // row of cells; cell 0 sees the incoming word as its left neighbor,
   // the last cell sees an empty right neighbor
   for (genvar i = 0; i < ND; i++) begin : g_cell
      dqu_pkg::cell_link_type left_link;
      dqu_pkg::cell_link_type right_link;

      if (i == 0) begin : g_first
         assign left_link.valid = 1'b1;
         assign left_link.data  = req_data_value;
      end else begin : g_mid_left
         assign left_link = links[i-1];
      end

      if (i == ND - 1) begin : g_last
         assign right_link.valid = 1'b0;
         assign right_link.data  = '0;
      end else begin : g_mid_right
         assign right_link = links[i+1];
      end

      dqu_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_link),
         .right_link (right_link),
         .own_link   (links[i]),
         .back_word  (back_words[i])
      );

      assign valid_vec[i] = links[i].valid;
   end

   // at most one cell flags itself as the back, so an or merges them
   always_comb begin
      back_or = '0;
      for (int k = 0; k < ND; k++) begin
         back_or = back_or | back_words[k];
      end
   end

   // result beat: fields read the state left by the command
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_is_empty    = queue_empty;
   assign rsp_is_full     = queue_full;
   assign rsp_entry_total = count_ff;
   assign rsp_front_word  = links[0].valid ? links[0].data : '0;
   assign rsp_back_word   = back_or;

   // checks
   `DQU_ASSERT_NEXT(a_rsp_follows_cmd, clock, reset, accept, rsp_valid_ff)
   `DQU_ASSERT_NOW(a_count_matches_cells, clock, reset, 1'b1,
      $countones(valid_vec) == int'(count_ff))
   `DQU_ASSERT_NOW(a_cells_packed_front, clock, reset, 1'b1,
      ((valid_vec >> 1) & ~valid_vec) == '0)
   `DQU_ASSERT_NEXT(a_overflow_keeps_full, clock, reset,
      accept && is_push && queue_full, count_ff == CW'(ND))
   `DQU_ASSERT_NEXT(a_underflow_keeps_empty, clock, reset,
      accept && !is_push && queue_empty, count_ff == '0)

endmodule
